// ===== src/mqub_pkg.sv =====
package mqub_pkg;

  localparam int FILL_W = 7;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_PULL   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [7:0] EMPTY_CODE = 8'd24;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] queue_id;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              parity_bit;
    logic [FILL_W-1:0] fill_count;
    logic              overflow;
    logic              empty_res;
  } out_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PULL,
    OP_STATUS,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] qid;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_slot_t;

  typedef enum logic {
    BK_IDLE,
    BK_DATA
  } back_state_t;

  function automatic logic odd_parity(input logic [7:0] b);
    return ~(^b);
  endfunction

endpackage

// ===== src/multi_queue_uart_byte_buffer.sv =====
// Shared byte store of 2*PORT_COUNT circular queues of QUEUE_DEPTH bytes:
// queues 0..PORT_COUNT-1 transmit, PORT_COUNT..2*PORT_COUNT-1 receive.
// Input channel (in_valid/in_stall/in_data): one item per request, cmd
// push, pull or status read (cmd 3 reads status). Output channel
// (out_valid/out_stall/out_data): exactly one result item per request, in
// order. An item is accepted at an edge with valid high and stall low.
// A two-entry command queue sits in front of the queue engine, so the input
// keeps taking items while the engine or the output is busy.
// The engine takes one item at a time: it reads the queue pointers and
// starts the store access in BK_IDLE and picks up the registered store
// read data in BK_DATA before it pops the next item.
// A stalled output holds its item; the engine then holds its finished result
// and the command queue fills, after which in_stall rises.
// Reset clears all pointers and fill counts and empties both channels; the
// byte store itself is not cleared and needs no clearing time.
module multi_queue_uart_byte_buffer
  import mqub_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int PORT_COUNT  = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  op_slot_t head;
  logic     pop;

  mqub_front #(
    .PORT_COUNT(PORT_COUNT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .head    (head),
    .pop     (pop)
  );

  mqub_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== src/mqub_front.sv =====
module mqub_front
  import mqub_pkg::*;
#(
  parameter int PORT_COUNT = 6
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_t      in_data,
  output op_slot_t head,
  input  logic     pop
);

  localparam int QUEUE_COUNT = 2 * PORT_COUNT;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;
  logic [1:0] level_next;
  op_t        op_in;
  logic       in_range;
  logic       push;
  logic       take;

  always_comb begin
    in_range    = {2'b00, in_data.queue_id} < 6'(QUEUE_COUNT);
    op_in.qid   = in_data.queue_id;
    op_in.data  = in_data.data_in;
    case (in_data.cmd)
      CMD_PUSH: op_in.kind = OP_PUSH;
      CMD_PULL: op_in.kind = OP_PULL;
      default:  op_in.kind = OP_STATUS;
    endcase
    if (!in_range) begin
      op_in.kind = OP_NONE;
      op_in.qid  = '0;
    end
  end

  assign in_stall = (level == 2'd2);
  assign push     = in_valid && !in_stall;
  assign take     = pop && (level != 2'd0);

  always_comb begin
    level_next = level;
    if (push && !take) begin
      level_next = level + 2'd1;
    end else if (take && !push) begin
      level_next = level - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  assign head.valid = (level != 2'd0);
  assign head.op    = slots[rd_ptr];

endmodule

// ===== src/mqub_back.sv =====
module mqub_back
  import mqub_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int PORT_COUNT  = 6
) (
  input  logic     clk,
  input  logic     rst,
  input  op_slot_t head,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  localparam int QUEUE_COUNT = 2 * PORT_COUNT;
  localparam int QIW         = $clog2(QUEUE_COUNT);
  localparam int IW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH   = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int AW          = $clog2(MEM_DEPTH);

  logic [IW-1:0] wr_idx [QUEUE_COUNT];
  logic [IW-1:0] rd_idx [QUEUE_COUNT];
  logic [CW-1:0] cnt    [QUEUE_COUNT];
  logic [7:0]    mem    [MEM_DEPTH];
  logic [7:0]    rd_data;

  back_state_t state;
  back_state_t state_next;

  logic              pend_pull;
  logic [7:0]        pend_code;
  logic [FILL_W-1:0] pend_fill;
  logic              pend_ovf;
  logic              pend_emp;

  logic [QIW-1:0] q;
  logic [IW-1:0]  cur_w;
  logic [IW-1:0]  cur_r;
  logic [CW-1:0]  cur_c;
  logic [CW-1:0]  c_next;
  logic [IW-1:0]  idx;
  logic [AW-1:0]  mem_addr;
  logic           mem_we;
  logic           mem_re;
  logic           res_pull;
  logic [7:0]     res_code;
  logic           res_ovf;
  logic           res_emp;
  logic           load;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (head.valid) state_next = BK_DATA;
      BK_DATA: if (load) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == BK_IDLE) && head.valid;
    load = (state == BK_DATA) && (!out_valid || !out_stall);
  end

  always_comb begin
    q        = QIW'(head.op.qid);
    cur_w    = wr_idx[q];
    cur_r    = rd_idx[q];
    cur_c    = cnt[q];
    c_next   = cur_c;
    idx      = cur_w;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_pull = 1'b0;
    res_code = 8'd0;
    res_ovf  = 1'b0;
    res_emp  = 1'b0;
    case (head.op.kind)
      OP_PUSH: begin
        if (cur_c == CW'(QUEUE_DEPTH)) begin
          res_ovf = 1'b1;
        end else begin
          mem_we = pop;
          c_next = cur_c + CW'(1);
        end
      end
      OP_PULL: begin
        idx = cur_r;
        if (cur_c == '0) begin
          res_emp  = 1'b1;
          res_code = EMPTY_CODE;
        end else begin
          mem_re   = pop;
          res_pull = 1'b1;
          c_next   = cur_c - CW'(1);
        end
      end
      default: ;
    endcase
    mem_addr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        wr_idx[i] <= '0;
        rd_idx[i] <= '0;
        cnt[i]    <= '0;
      end
    end else begin
      if (mem_we) begin
        wr_idx[q] <= (cur_w == IW'(QUEUE_DEPTH - 1)) ? '0 : cur_w + IW'(1);
        cnt[q]    <= c_next;
      end
      if (mem_re) begin
        rd_idx[q] <= (cur_r == IW'(QUEUE_DEPTH - 1)) ? '0 : cur_r + IW'(1);
        cnt[q]    <= c_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= head.op.data;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_pull <= res_pull;
      pend_code <= res_code;
      pend_ovf  <= res_ovf;
      pend_emp  <= res_emp;
      pend_fill <= (head.op.kind == OP_NONE) ? '0 : FILL_W'(c_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.data_out   <= pend_pull ? rd_data : pend_code;
      out_data.parity_bit <= pend_pull && odd_parity(rd_data);
      out_data.fill_count <= pend_fill;
      out_data.overflow   <= pend_ovf;
      out_data.empty_res  <= pend_emp;
    end
  end

endmodule

// ===== src/mqub_checker.sv =====
module mqub_checker
  import mqub_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_empty_pull: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_res |->
      out_data.data_out == EMPTY_CODE && out_data.fill_count == '0 &&
      !out_data.parity_bit && !out_data.overflow)
    else $error("bad empty pull result");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      out_data.data_out == 8'd0 && !out_data.parity_bit && !out_data.empty_res)
    else $error("bad overflow result");

endmodule

bind multi_queue_uart_byte_buffer mqub_checker u_checker (.*);

// ===== dv/mqub_result_checker.sv =====
module mqub_result_checker
  import mqub_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int PORT_COUNT  = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   full_refusals,
  output int   empty_pulls
);

  localparam int QUEUE_COUNT = 2 * PORT_COUNT;

  logic [7:0] slots [QUEUE_COUNT][QUEUE_DEPTH];
  int         wr_slot [QUEUE_COUNT];
  int         rd_slot [QUEUE_COUNT];
  int         held    [QUEUE_COUNT];
  out_t       due_results [$];

  function automatic out_t apply_request(input in_t req);
    out_t res;
    int   q;
    res = '0;
    q   = int'(req.queue_id);
    if (q < QUEUE_COUNT) begin
      case (req.cmd)
        CMD_PUSH: begin
          if (held[q] >= QUEUE_DEPTH) begin
            res.overflow = 1'b1;
          end else begin
            slots[q][wr_slot[q]] = req.data_in;
            wr_slot[q] = (wr_slot[q] + 1 >= QUEUE_DEPTH) ? 0 : wr_slot[q] + 1;
            held[q]++;
          end
        end
        CMD_PULL: begin
          if (held[q] == 0) begin
            res.data_out  = EMPTY_CODE;
            res.empty_res = 1'b1;
          end else begin
            res.data_out   = slots[q][rd_slot[q]];
            res.parity_bit = 1'b1 ^ (^res.data_out);
            rd_slot[q] = (rd_slot[q] + 1 >= QUEUE_DEPTH) ? 0 : rd_slot[q] + 1;
            held[q]--;
          end
        end
        default: ;
      endcase
      res.fill_count = held[q][FILL_W-1:0];
    end
    return res;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        wr_slot[q] = 0;
        rd_slot[q] = 0;
        held[q]    = 0;
      end
      due_results.delete();
      fail_count    = 0;
      full_refusals = 0;
      empty_pulls   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_request(in_data));
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result item with no request outstanding: %h", out_data);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("data_out", int'(want.data_out), int'(out_data.data_out));
          check_field("parity_bit", int'(want.parity_bit), int'(out_data.parity_bit));
          check_field("fill_count", int'(want.fill_count), int'(out_data.fill_count));
          check_field("overflow", int'(want.overflow), int'(out_data.overflow));
          check_field("empty_res", int'(want.empty_res), int'(out_data.empty_res));
          if (want.overflow) full_refusals++;
          if (want.empty_res) empty_pulls++;
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== dv/tb_multi_queue_uart_byte_buffer.sv =====
module tb_multi_queue_uart_byte_buffer;
  import mqub_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int PORT_COUNT  = 6;
  localparam int QUEUE_COUNT = 2 * PORT_COUNT;
  localparam int REQUEST_TARGET = 750;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int fail_count;
  int pending;
  int full_refusals;
  int empty_pulls;
  int requests_sent = 0;
  int send_idle     = 0;
  int recv_stall    = 0;
  int quiet_cycles  = 0;

  multi_queue_uart_byte_buffer #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  mqub_result_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .full_refusals(full_refusals),
    .empty_pulls  (empty_pulls)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic pick_idling();
    idle_mode_t mode;
    mode = idle_mode_t'((requests_sent / 50) % 4);
    case (mode)
      IDLE_NONE: begin
        send_idle  = 0;
        recv_stall = 0;
      end
      IDLE_SENDER: begin
        send_idle  = 86;
        recv_stall = 0;
      end
      IDLE_RECEIVER: begin
        send_idle  = 0;
        recv_stall = 86;
      end
      default: begin
        send_idle  = 12;
        recv_stall = 12;
      end
    endcase
  endtask

  task automatic send_request(input logic [1:0] cmd, input logic [3:0] qid,
                              input logic [7:0] data);
    in_t req;
    req.cmd      = cmd;
    req.queue_id = qid;
    req.data_in  = data;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (qid < QUEUE_COUNT) requests_sent++;
    pick_idling();
  endtask

  initial begin
    int q;
    int len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(CMD_PULL, 4'd0, 8'h00);
    send_request(CMD_STATUS, 4'd0, 8'h00);
    send_request(CMD_PUSH, 4'd0, 8'h00);
    send_request(CMD_PUSH, 4'd0, 8'hFF);
    send_request(CMD_PUSH, 4'd0, 8'hA5);
    send_request(CMD_PUSH, 4'(QUEUE_COUNT - 1), 8'h5A);
    send_request(CMD_PUSH, 4'(PORT_COUNT - 1), 8'h01);
    send_request(CMD_PUSH, 4'(PORT_COUNT), 8'h80);
    send_request(CMD_UNUSED, 4'(QUEUE_COUNT - 1), 8'hFF);
    send_request(CMD_PULL, 4'd0, 8'hFF);
    send_request(CMD_PULL, 4'd0, 8'h00);
    send_request(CMD_PULL, 4'd0, 8'h00);
    send_request(CMD_PULL, 4'd0, 8'h00);
    send_request(CMD_PULL, 4'(QUEUE_COUNT - 1), 8'h00);
    send_request(CMD_PULL, 4'(PORT_COUNT - 1), 8'h00);
    send_request(CMD_PULL, 4'(PORT_COUNT), 8'h00);
    send_request(CMD_PULL, 4'(PORT_COUNT), 8'h00);
    send_request(CMD_PUSH, 4'd12, 8'h3C);
    send_request(CMD_PULL, 4'd15, 8'hC3);
    send_request(CMD_STATUS, 4'd13, 8'h00);
    send_request(CMD_UNUSED, 4'd14, 8'hFF);

    while (requests_sent < REQUEST_TARGET) begin
      q   = $urandom_range(0, QUEUE_COUNT - 1);
      len = $urandom_range(0, 1) ? $urandom_range(60, 70) : $urandom_range(1, 20);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat (len) send_request(CMD_PUSH, 4'(q), 8'($urandom_range(0, 255)));
        end
        3, 4, 5: begin
          repeat (len) send_request(CMD_PULL, 4'(q), 8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 8)) begin
            send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d requests over %0d queues of depth %0d", requests_sent,
             QUEUE_COUNT, QUEUE_DEPTH);
    $display("summary: %0d pushes refused on full queues, %0d pulls from empty queues",
             full_refusals, empty_pulls);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
